// ===== rtl/core/tfn_pkg.sv =====
// Shared types and fixed widths for the triangle face normal pipeline.
// No dependencies; every other file but tfn_if imports this package.
package tfn_pkg;

  localparam int FIT_W  = 17;  // fitted edge component, signed
  localparam int PROD_W = 34;  // one partial cross product, signed
  localparam int MAG_W  = 34;  // cross component magnitude
  localparam int NRM_W  = 30;  // block-scaled magnitude, largest in [2^29, 2^30)
  localparam int HALF_W = 15;  // half of a scaled magnitude
  localparam int SUM_W  = 62;  // sum of squared scaled magnitudes
  localparam int ROOT_W = 31;  // integer square root of the sum
  localparam int Q_W    = 15;  // quotient magnitude, up to 16384
  localparam int OUT_W  = 16;  // Q1.14 result component

  typedef struct packed {
    logic [5:0][PROD_W-1:0] p;
  } prod_t;

  typedef struct packed {
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][NRM_W-1:0] mag;
  } nrm_t;

endpackage

// ===== rtl/core/tfn_if.sv =====
// Channel interfaces of the face normal block: triangle in, normal out.
// Depends on nothing.
interface tfn_tri_if #(parameter int COORD_BITS = 16);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;
  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  input ready);
  modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  output ready);
endinterface

interface tfn_nrm_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic              degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ===== rtl/core/triangle_face_normal.sv =====
// Triangle face normal: unit normal in Q1.14 from three Q8.8 vertices.
// Depends on tfn_pkg, tfn_if, tfn_front, tfn_scale, tfn_sqrt, tfn_div.
//
// Usage: present one triangle per transaction on in_tri (valid/ready);
// each triangle yields exactly one transaction on out_nrm carrying
// normal_x/y/z and the degenerate flag (zero normal, flag set, when the
// cross product is zero).
// Pipeline: an input transaction passes the front end (edges, edge
// fit, products), scaling and sum of squares, the square root at two
// root bits a stage (one in the last), and division at two quotient
// bits a stage (one in the last) plus the sign stage to output valid.
// Throughput: one triangle per cycle while not stalled; every stage is
// a register stage that takes a new transaction each cycle it advances.
// Stall: when out_nrm.ready is low while a result is waiting, the whole
// pipeline holds and in_tri.ready drops; nothing is lost or repeated.
// Reset: rst_n clears all valid bits; payload registers are not reset.
// No state is kept between triangles.
module triangle_face_normal import tfn_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  tfn_tri_if.sink  in_tri,
  tfn_nrm_if.source out_nrm
);

  logic                       en;
  logic [8:0][COORD_BITS-1:0] crd;
  logic                       f_v, s_v, q_v, d_v;
  prod_t                      f_prod;
  nrm_t                       s_nrm, q_nrm;
  logic [SUM_W-1:0]           s_sum;
  logic [ROOT_W-1:0]          q_root;
  logic [2:0][OUT_W-1:0]      d_comp;
  logic                       d_degen;

  // Advance the whole pipeline unless a result is waiting and stalled
  assign en           = !d_v || out_nrm.ready;
  assign in_tri.ready = en;

  assign crd = {in_tri.v2_z, in_tri.v2_y, in_tri.v2_x,
                in_tri.v1_z, in_tri.v1_y, in_tri.v1_x,
                in_tri.v0_z, in_tri.v0_y, in_tri.v0_x};

  tfn_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk, .rst_n, .en,
    .in_valid (in_tri.valid),
    .crd      (crd),
    .out_valid(f_v),
    .out_prod (f_prod)
  );

  tfn_scale u_scale (
    .clk, .rst_n, .en,
    .in_valid (f_v),
    .in_prod  (f_prod),
    .out_valid(s_v),
    .out_nrm  (s_nrm),
    .out_sum  (s_sum)
  );

  tfn_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (s_v),
    .in_nrm   (s_nrm),
    .in_sum   (s_sum),
    .out_valid(q_v),
    .out_nrm  (q_nrm),
    .out_root (q_root)
  );

  tfn_div u_div (
    .clk, .rst_n, .en,
    .in_valid (q_v),
    .in_nrm   (q_nrm),
    .in_root  (q_root),
    .out_valid(d_v),
    .out_comp (d_comp),
    .out_degen(d_degen)
  );

  assign out_nrm.valid      = d_v;
  assign out_nrm.normal_x   = d_comp[0];
  assign out_nrm.normal_y   = d_comp[1];
  assign out_nrm.normal_z   = d_comp[2];
  assign out_nrm.degenerate = d_degen;

endmodule

// ===== rtl/core/tfn_front.sv =====
// Front end: edges, edge fit to 17-bit signed, six cross partial products.
// Three register stages. Depends on tfn_pkg.
module tfn_front import tfn_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [8:0][COORD_BITS-1:0] crd,
  output logic                       out_valid,
  output prod_t                      out_prod
);

  localparam int EW = COORD_BITS + 1;
  localparam int SW = $clog2(EW + 1);

  logic [2:0]         v_r;
  logic [2:0][EW-1:0] e0_r, e1_r, e0_nxt, e1_nxt;
  logic [2:0][FIT_W-1:0] f0_r, f1_r, f0_nxt, f1_nxt;
  prod_t prod_r, prod_nxt;

  // Shift an edge down until its largest magnitude is below 2^16
  function automatic logic [2:0][FIT_W-1:0] fit(input logic [2:0][EW-1:0] e);
    logic [2:0][EW-1:0] m;
    logic [EW-1:0]      mx;
    logic [SW-1:0]      s;
    logic [EW+15:0]     ext;
    logic [15:0]        fm;
    logic [2:0][FIT_W-1:0] r;
    mx = '0;
    s  = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = e[i][EW-1] ? (EW'(0) - e[i]) : e[i];
      if (m[i] > mx) mx = m[i];
    end
    for (int i = 0; i < EW; i++) begin
      if (({16'b0, mx} >> i) >= (EW+16)'(65536)) s = SW'(i + 1);
    end
    for (int i = 0; i < 3; i++) begin
      ext  = {16'b0, m[i]} >> s;
      fm   = ext[15:0];
      r[i] = e[i][EW-1] ? (FIT_W'(0) - {1'b0, fm}) : {1'b0, fm};
    end
    return r;
  endfunction

  // Form edges from sign-extended vertices
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e0_nxt[i] = {crd[3+i][COORD_BITS-1], crd[3+i]} - {crd[i][COORD_BITS-1], crd[i]};
      e1_nxt[i] = {crd[6+i][COORD_BITS-1], crd[6+i]} - {crd[i][COORD_BITS-1], crd[i]};
    end
  end

  always_comb begin
    f0_nxt = fit(e0_r);
    f1_nxt = fit(e1_r);
  end

  // Partial products of the cross product
  always_comb begin
    prod_nxt.p[0] = PROD_W'($signed(f0_r[1]) * $signed(f1_r[2]));
    prod_nxt.p[1] = PROD_W'($signed(f0_r[2]) * $signed(f1_r[1]));
    prod_nxt.p[2] = PROD_W'($signed(f0_r[2]) * $signed(f1_r[0]));
    prod_nxt.p[3] = PROD_W'($signed(f0_r[0]) * $signed(f1_r[2]));
    prod_nxt.p[4] = PROD_W'($signed(f0_r[0]) * $signed(f1_r[1]));
    prod_nxt.p[5] = PROD_W'($signed(f0_r[1]) * $signed(f1_r[0]));
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      e0_r   <= e0_nxt;
      e1_r   <= e1_nxt;
      f0_r   <= f0_nxt;
      f1_r   <= f1_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = v_r[2];
  assign out_prod  = prod_r;

endmodule

// ===== rtl/core/tfn_scale.sv =====
// Cross product, block scaling to [2^29, 2^30) and sum of squares.
// Five register stages. Depends on tfn_pkg.
module tfn_scale import tfn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  prod_t            in_prod,
  output logic             out_valid,
  output nrm_t             out_nrm,
  output logic [SUM_W-1:0] out_sum
);

  logic [4:0]            v_r;
  logic [2:0][MAG_W-1:0] ma_r, ma_nxt, mb_r;
  logic [2:0]            na_r, na_nxt, nb_r;
  logic [5:0]            lead_r, lead_nxt;
  logic                  dg_r, dg_nxt;
  nrm_t                  nc_r, nc_nxt, nd_r, ne_r;
  logic [2:0][2*HALF_W-1:0] aa_r, ab_r, bb_r, aa_nxt, ab_nxt, bb_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;

  // Subtract partial products, split into sign and magnitude
  always_comb begin
    logic signed [MAG_W:0] c;
    for (int i = 0; i < 3; i++) begin
      c = $signed({in_prod.p[2*i][PROD_W-1], in_prod.p[2*i]})
        - $signed({in_prod.p[2*i+1][PROD_W-1], in_prod.p[2*i+1]});
      na_nxt[i] = c[MAG_W];
      ma_nxt[i] = c[MAG_W] ? MAG_W'(-c) : MAG_W'(c);
    end
  end

  // Find the leading one of the largest magnitude
  always_comb begin
    logic [MAG_W-1:0] mx;
    mx = '0;
    lead_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      if (ma_r[i] > mx) mx = ma_r[i];
    end
    for (int i = 0; i < MAG_W; i++) begin
      if (mx[i]) lead_nxt = 6'(i);
    end
    dg_nxt = (mx == '0);
  end

  // Shift all magnitudes by the common amount
  always_comb begin
    logic [MAG_W-1:0] t;
    nc_nxt.degen = dg_r;
    nc_nxt.neg   = nb_r;
    for (int i = 0; i < 3; i++) begin
      if (lead_r < 6'(NRM_W - 1)) t = mb_r[i] << (6'(NRM_W - 1) - lead_r);
      else                        t = mb_r[i] >> (lead_r - 6'(NRM_W - 1));
      nc_nxt.mag[i] = t[NRM_W-1:0];
    end
  end

  // Partial squares on 15-bit halves
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aa_nxt[i] = nc_r.mag[i][NRM_W-1:HALF_W] * nc_r.mag[i][NRM_W-1:HALF_W];
      ab_nxt[i] = nc_r.mag[i][NRM_W-1:HALF_W] * nc_r.mag[i][HALF_W-1:0];
      bb_nxt[i] = nc_r.mag[i][HALF_W-1:0] * nc_r.mag[i][HALF_W-1:0];
    end
  end

  // Reassemble and add the squares
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      sum_nxt = sum_nxt + ({SUM_W{1'b0}} | (SUM_W'(aa_r[i]) << (2*HALF_W)))
                        + (SUM_W'(ab_r[i]) << (HALF_W + 1)) + SUM_W'(bb_r[i]);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= ma_nxt;
      na_r   <= na_nxt;
      mb_r   <= ma_r;
      nb_r   <= na_r;
      lead_r <= lead_nxt;
      dg_r   <= dg_nxt;
      nc_r   <= nc_nxt;
      aa_r   <= aa_nxt;
      ab_r   <= ab_nxt;
      bb_r   <= bb_nxt;
      nd_r   <= nc_r;
      sum_r  <= sum_nxt;
      ne_r   <= nd_r;
    end
  end

  assign out_valid = v_r[4];
  assign out_nrm   = ne_r;
  assign out_sum   = sum_r;

endmodule

// ===== rtl/core/tfn_sqrt.sv =====
// Pipelined integer square root, two result bits per stage (one in the last), 16 stages.
// Carries the scaled vector alongside. Depends on tfn_pkg.
module tfn_sqrt import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  nrm_t              in_nrm,
  input  logic [SUM_W-1:0]  in_sum,
  output logic              out_valid,
  output nrm_t              out_nrm,
  output logic [ROOT_W-1:0] out_root
);

  localparam int NSTG  = (ROOT_W + 1) / 2;
  localparam int REM_W = ROOT_W + 4;

  logic [NSTG:0]     v_s;
  logic [REM_W-1:0]  rem_s  [NSTG+1];
  logic [ROOT_W-1:0] root_s [NSTG+1];
  logic [SUM_W-1:0]  x_s    [NSTG+1];
  nrm_t              n_s    [NSTG+1];

  assign v_s[0]    = in_valid;
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign x_s[0]    = in_sum;
  assign n_s[0]    = in_nrm;

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    localparam int NSTEP = (ROOT_W - 2*g >= 2) ? 2 : 1;
    logic              v_r;
    logic [REM_W-1:0]  rem_r, rem_nxt;
    logic [ROOT_W-1:0] root_r, root_nxt;
    logic [SUM_W-1:0]  x_r, x_nxt;
    nrm_t              n_r;

    // Take one result bit per step from the next pair of input bits
    always_comb begin
      logic [REM_W-1:0] trial;
      rem_nxt  = rem_s[g];
      root_nxt = root_s[g];
      x_nxt    = x_s[g];
      for (int k = 0; k < NSTEP; k++) begin
        rem_nxt = {rem_nxt[REM_W-3:0], x_nxt[SUM_W-1:SUM_W-2]};
        x_nxt   = x_nxt << 2;
        trial   = {2'b00, root_nxt, 2'b01};
        if (rem_nxt >= trial) begin
          rem_nxt  = rem_nxt - trial;
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        x_r    <= x_nxt;
        n_r    <= n_s[g];
      end
    end

    assign v_s[g+1]    = v_r;
    assign rem_s[g+1]  = rem_r;
    assign root_s[g+1] = root_r;
    assign x_s[g+1]    = x_r;
    assign n_s[g+1]    = n_r;
  end

  assign out_valid = v_s[NSTG];
  assign out_nrm   = n_s[NSTG];
  assign out_root  = root_s[NSTG];

endmodule

// ===== rtl/core/tfn_div.sv =====
// Pipelined restoring division of each component by the length, two
// quotient bits per stage (one in the last), then sign and degenerate handling. Depends on tfn_pkg.
module tfn_div import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  nrm_t              in_nrm,
  input  logic [ROOT_W-1:0] in_root,
  output logic              out_valid,
  output logic [2:0][OUT_W-1:0] out_comp,
  output logic              out_degen
);

  localparam int NSTG  = (Q_W + 1) / 2;
  localparam int DEN_W = ROOT_W + 1;
  localparam int REM_W = DEN_W + 1;
  localparam int NUM_W = NRM_W + Q_W + 1;

  logic [NSTG:0]             v_s;
  logic [2:0][REM_W-1:0]     rem_s [NSTG+1];
  logic [2:0][Q_W-1:0]       low_s [NSTG+1];
  logic [2:0][Q_W-1:0]       q_s   [NSTG+1];
  logic [DEN_W-1:0]          d_s   [NSTG+1];
  logic [3:0]                f_s   [NSTG+1];  // degen and signs
  logic                      vo_r;
  logic [2:0][OUT_W-1:0]     comp_r, comp_nxt;
  logic                      dg_r;

  // Numerator mag*2^15 + L over denominator 2L
  always_comb begin
    logic [NUM_W-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num         = {1'b0, in_nrm.mag[i], {Q_W{1'b0}}} + NUM_W'(in_root);
      rem_s[0][i] = REM_W'(num[NUM_W-1:Q_W]);
      low_s[0][i] = num[Q_W-1:0];
      q_s[0][i]   = '0;
    end
  end
  assign v_s[0] = in_valid;
  assign d_s[0] = {in_root, 1'b0};
  assign f_s[0] = {in_nrm.degen, in_nrm.neg};

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    localparam int NSTEP = (Q_W - 2*g >= 2) ? 2 : 1;
    logic                  v_r;
    logic [2:0][REM_W-1:0] rem_r, rem_nxt;
    logic [2:0][Q_W-1:0]   low_r, low_nxt, q_r, q_nxt;
    logic [DEN_W-1:0]      d_r;
    logic [3:0]            f_r;

    // Shift in one numerator bit and trial-subtract per step
    always_comb begin
      rem_nxt = rem_s[g];
      low_nxt = low_s[g];
      q_nxt   = q_s[g];
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < NSTEP; k++) begin
          rem_nxt[i] = {rem_nxt[i][REM_W-2:0], low_nxt[i][Q_W-1]};
          low_nxt[i] = low_nxt[i] << 1;
          if (rem_nxt[i] >= {1'b0, d_s[g]}) begin
            rem_nxt[i] = rem_nxt[i] - {1'b0, d_s[g]};
            q_nxt[i]   = {q_nxt[i][Q_W-2:0], 1'b1};
          end else begin
            q_nxt[i]   = {q_nxt[i][Q_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_s[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= rem_nxt;
        low_r <= low_nxt;
        q_r   <= q_nxt;
        d_r   <= d_s[g];
        f_r   <= f_s[g];
      end
    end

    assign v_s[g+1]   = v_r;
    assign rem_s[g+1] = rem_r;
    assign low_s[g+1] = low_r;
    assign q_s[g+1]   = q_r;
    assign d_s[g+1]   = d_r;
    assign f_s[g+1]   = f_r;
  end

  // Apply signs, zero the result of a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_s[NSTG][3])      comp_nxt[i] = '0;
      else if (f_s[NSTG][i]) comp_nxt[i] = OUT_W'(0) - {1'b0, q_s[NSTG][i]};
      else                   comp_nxt[i] = {1'b0, q_s[NSTG][i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_s[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_r <= comp_nxt;
      dg_r   <= f_s[NSTG][3];
    end
  end

  assign out_valid = vo_r;
  assign out_comp  = comp_r;
  assign out_degen = dg_r;

endmodule
